>>> sv/assert_macros.svh
// Shared assertion macros for the heap queue checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HPQ_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("heap queue check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define HPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("heap queue check failed: next-cycle rule");

`endif

>>> sv/hpq_pkg.sv
`default_nettype none

package hpq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // Request type codes.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_hpq_status;

    // One request item.
    typedef struct packed {
        logic                      req_type;
        logic signed [VALUE_W-1:0] value;
    } t_hpq_req;

    // One result item.
    typedef struct packed {
        t_hpq_status               status;
        logic signed [VALUE_W-1:0] removed_value;
        logic [COUNT_W-1:0]        count;
    } t_hpq_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        accept;
        logic        load_ins;
        logic        rd_parent;
        logic        ins_move;
        logic        wr_item;
        logic        rd_del;
        logic        del_load;
        logic        rd_child;
        logic        sd_move;
        logic        finish;
        t_hpq_status res_status;
    } t_hpq_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic root;
        logic ins_gt;
        logic child_out;
        logic sd_gt;
    } t_hpq_stat;

endpackage

`default_nettype wire

>>> sv/max_heap_priority_queue.sv
// Insert: the new value climbs toward the root one heap level at a time until it stops.
// Delete: the last entry replaces the root and sinks one heap level at a time toward a leaf.
// Overflow and underflow: the result is shown in the cycle after the accept.
// Each heap level takes a memory read step, then a compare and write step.
// The next item can be accepted while its predecessor's result is shown; no receiver stall.
// Synchronous active-low reset empties the queue; stored values are not cleared.
`default_nettype none

module max_heap_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire hpq_pkg::t_hpq_req  i_req,
    output logic                    busy,
    output logic                    o_done,
    output hpq_pkg::t_hpq_res       o_res
);

    hpq_pkg::t_hpq_cmd  cmd;
    hpq_pkg::t_hpq_stat stat;

    // Sequencer for insert and delete.
    hpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    // Heap memory, working registers and result register.
    hpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

>>> sv/hpq_datapath.sv
`default_nettype none

module hpq_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire hpq_pkg::t_hpq_req i_req,
    input  wire hpq_pkg::t_hpq_cmd i_cmd,
    output hpq_pkg::t_hpq_stat     o_stat,
    output logic                   o_done,
    output hpq_pkg::t_hpq_res      o_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam int VW = hpq_pkg::VALUE_W;

    // Heap storage, one write port and two registered read ports.
    logic signed [VW-1:0] r_mem [CAPACITY];
    logic signed [VW-1:0] r_rd_a;
    logic signed [VW-1:0] r_rd_b;

    logic signed [VW-1:0] r_item;
    logic signed [VW-1:0] r_removed;
    logic [AW-1:0]        r_pos;
    logic [CW-1:0]        r_count;
    logic                 r_done;
    hpq_pkg::t_hpq_res    r_res;

    logic [IW-1:0]        pos_w;
    logic [IW-1:0]        cnt_w;
    logic [IW-1:0]        child_a;
    logic [IW-1:0]        child_b;
    logic                 has_b;
    logic [AW-1:0]        parent;
    logic                 sel_b;
    logic signed [VW-1:0] sel_val;
    logic [AW-1:0]        sel_idx;
    logic [AW-1:0]        rd_addr_a;
    logic [AW-1:0]        rd_addr_b;
    logic                 wr_en;
    logic signed [VW-1:0] wr_data;

    // Tree navigation around the current position.
    always_comb begin
        pos_w   = IW'(r_pos);
        cnt_w   = IW'(r_count);
        child_a = (pos_w << 1) + IW'(1);
        child_b = child_a + IW'(1);
        has_b   = child_b < cnt_w;
        parent  = (r_pos - AW'(1)) >> 1;
        sel_b   = has_b && (r_rd_b > r_rd_a);
        sel_val = sel_b ? r_rd_b : r_rd_a;
        sel_idx = sel_b ? AW'(child_b) : AW'(child_a);
    end

    // Read address selection.
    always_comb begin
        rd_addr_a = '0;
        rd_addr_b = '0;
        if (i_cmd.rd_parent) begin
            rd_addr_a = parent;
        end else if (i_cmd.rd_del) begin
            rd_addr_b = AW'(r_count - CW'(1));
        end else if (i_cmd.rd_child) begin
            rd_addr_a = AW'(child_a);
            rd_addr_b = has_b ? AW'(child_b) : AW'(child_a);
        end
    end

    // Write data selection; the write always lands at the current position.
    always_comb begin
        wr_en   = i_cmd.wr_item | i_cmd.ins_move | i_cmd.sd_move;
        wr_data = r_item;
        if (i_cmd.ins_move) begin
            wr_data = r_rd_a;
        end else if (i_cmd.sd_move) begin
            wr_data = sel_val;
        end
    end

    // Memory array.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    // Working registers of the current item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_removed <= '0;
        end
        if (i_cmd.load_ins) begin
            r_item <= i_req.value;
            r_pos  <= AW'(r_count);
        end else if (i_cmd.del_load) begin
            r_item    <= r_rd_b;
            r_removed <= r_rd_a;
            r_pos     <= '0;
        end else if (i_cmd.ins_move) begin
            r_pos <= parent;
        end else if (i_cmd.sd_move) begin
            r_pos <= sel_idx;
        end
        if (i_cmd.finish) begin
            r_res.status        <= i_cmd.res_status;
            r_res.removed_value <= (i_cmd.res_status == hpq_pkg::ST_OK) ? r_removed : '0;
            r_res.count         <= hpq_pkg::COUNT_W'(r_count);
        end
    end

    // Entry count and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.load_ins) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.del_load) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Status back to the controller.
    always_comb begin
        o_stat.full      = r_count == CW'(CAPACITY);
        o_stat.empty     = r_count == '0;
        o_stat.root      = r_pos == '0;
        o_stat.ins_gt    = r_item > r_rd_a;
        o_stat.child_out = child_a >= cnt_w;
        o_stat.sd_gt     = sel_val > r_item;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

>>> sv/hpq_ctrl.sv
`default_nettype none

module hpq_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_req_type,
    input  wire hpq_pkg::t_hpq_stat i_stat,
    output hpq_pkg::t_hpq_cmd       o_cmd,
    output logic                    o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_DEL_LOAD,
        S_SD_RD,
        S_SD_CMP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    // Next state and command decode.
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.res_status = hpq_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_req_type == hpq_pkg::REQ_INSERT) begin
                        if (i_stat.full) begin
                            o_cmd.finish     = 1'b1;
                            o_cmd.res_status = hpq_pkg::ST_OVERFLOW;
                        end else begin
                            o_cmd.load_ins = 1'b1;
                            n_state        = S_INS_RD;
                        end
                    end else if (i_stat.empty) begin
                        o_cmd.finish     = 1'b1;
                        o_cmd.res_status = hpq_pkg::ST_UNDERFLOW;
                    end else begin
                        o_cmd.rd_del = 1'b1;
                        n_state      = S_DEL_LOAD;
                    end
                end
            end
            // Sift up: fetch the parent unless already at the root.
            S_INS_RD: begin
                if (i_stat.root) begin
                    o_cmd.wr_item = 1'b1;
                    o_cmd.finish  = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_parent = 1'b1;
                    n_state         = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_stat.ins_gt) begin
                    o_cmd.ins_move = 1'b1;
                    n_state        = S_INS_RD;
                end else begin
                    o_cmd.wr_item = 1'b1;
                    o_cmd.finish  = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            // Capture the root and the last entry, then sift down.
            S_DEL_LOAD: begin
                o_cmd.del_load = 1'b1;
                n_state        = S_SD_RD;
            end
            S_SD_RD: begin
                if (i_stat.child_out) begin
                    o_cmd.wr_item = 1'b1;
                    o_cmd.finish  = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.rd_child = 1'b1;
                    n_state        = S_SD_CMP;
                end
            end
            S_SD_CMP: begin
                if (i_stat.sd_gt) begin
                    o_cmd.sd_move = 1'b1;
                    n_state       = S_SD_RD;
                end else begin
                    o_cmd.wr_item = 1'b1;
                    o_cmd.finish  = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_state != S_IDLE;
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

>>> sv/hpq_checker.sv
`default_nettype none
`include "assert_macros.svh"

module hpq_checker #(
    parameter int CAPACITY = 16
) (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_start,
    input wire logic              i_busy,
    input wire logic              i_done,
    input wire hpq_pkg::t_hpq_res i_res
);

    logic ovf_shown;
    logic ovf_holds;
    logic unf_shown;
    logic unf_holds;

    // Result kinds and what each one must show.
    assign ovf_shown = i_done && i_res.status == hpq_pkg::ST_OVERFLOW;
    assign ovf_holds = i_res.count == 5'(CAPACITY) && i_res.removed_value == '0;
    assign unf_shown = i_done && i_res.status == hpq_pkg::ST_UNDERFLOW;
    assign unf_holds = i_res.count == '0 && i_res.removed_value == '0;

    // A result is only shown while the block is free for the next item.
    `HPQ_ASSERT_SAME(a_done_not_busy, i_clk, i_rst_n, i_done, !i_busy)

    // An accepted item either starts work or answers at once.
    `HPQ_ASSERT_NEXT(a_accept_moves, i_clk, i_rst_n, i_start && !i_busy, i_busy || i_done)

    // Work never ends without a result.
    `HPQ_ASSERT_SAME(a_busy_ends_done, i_clk, i_rst_n, $fell(i_busy) && $past(i_rst_n), i_done)

    // Overflow only with a full queue, and nothing is returned.
    `HPQ_ASSERT_SAME(a_overflow_full, i_clk, i_rst_n, ovf_shown, ovf_holds)

    // Underflow only with an empty queue, and nothing is returned.
    `HPQ_ASSERT_SAME(a_underflow_empty, i_clk, i_rst_n, unf_shown, unf_holds)

endmodule

bind max_heap_priority_queue hpq_checker #(
    .CAPACITY (CAPACITY)
) u_hpq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (start),
    .i_busy  (busy),
    .i_done  (o_done),
    .i_res   (o_res)
);

`default_nettype wire

>>> verif/hpq_result_checker.sv
module hpq_result_checker #(
    parameter int CAPACITY = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic         i_busy,
    input  hpq_pkg::t_hpq_req i_req,
    input  wire logic         i_done,
    input  hpq_pkg::t_hpq_res i_res,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_W = hpq_pkg::VALUE_W;
    localparam int COUNT_W = hpq_pkg::COUNT_W;

    // Shadow copy of the queue contents, kept as a 0-based max heap.
    logic signed [VALUE_W-1:0] heap_vals [CAPACITY];
    int                        held_count;

    // Results predicted for accepted items, oldest first.
    hpq_pkg::t_hpq_res         expected_results [$];
    hpq_pkg::t_hpq_res         oldest;

    // Applies one request to the shadow heap and returns the result it should produce.
    function automatic hpq_pkg::t_hpq_res apply_request(input hpq_pkg::t_hpq_req req);
        hpq_pkg::t_hpq_res         res;
        logic signed [VALUE_W-1:0] item;
        int                        pos;
        int                        parent;
        int                        child;
        logic                      moving;
        res.status        = hpq_pkg::ST_OK;
        res.removed_value = '0;
        if (req.req_type == hpq_pkg::REQ_INSERT) begin
            if (held_count >= CAPACITY) begin
                res.status = hpq_pkg::ST_OVERFLOW;
            end else begin
                // Place the new value at the end and let it climb toward the root.
                item       = req.value;
                pos        = held_count;
                held_count = held_count + 1;
                moving     = 1'b1;
                while (moving && pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (item > heap_vals[parent]) begin
                        heap_vals[pos] = heap_vals[parent];
                        pos            = parent;
                    end else begin
                        moving = 1'b0;
                    end
                end
                heap_vals[pos] = item;
            end
        end else begin
            if (held_count == 0) begin
                res.status = hpq_pkg::ST_UNDERFLOW;
            end else begin
                // Take the root, move the last entry up and let it sink.
                res.removed_value = heap_vals[0];
                held_count        = held_count - 1;
                if (held_count > 0) begin
                    item   = heap_vals[held_count];
                    pos    = 0;
                    moving = 1'b1;
                    while (moving && (2 * pos + 1) < held_count) begin
                        child = 2 * pos + 1;
                        if (child + 1 < held_count && heap_vals[child + 1] > heap_vals[child]) begin
                            child = child + 1;
                        end
                        if (heap_vals[child] > item) begin
                            heap_vals[pos] = heap_vals[child];
                            pos            = child;
                        end else begin
                            moving = 1'b0;
                        end
                    end
                    heap_vals[pos] = item;
                end
            end
        end
        res.count = COUNT_W'(held_count);
        return res;
    endfunction

    // Compare each strobed result before recording the item accepted at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            expected_results.delete();
        end else begin
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    $error("result strobed with no item outstanding");
                    o_fail_count = o_fail_count + 1;
                end else begin
                    oldest = expected_results.pop_front();
                    if (i_res.status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d", oldest.status, i_res.status);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_res.removed_value !== oldest.removed_value) begin
                        $error("removed_value: expected %0d, actual %0d",
                               oldest.removed_value, i_res.removed_value);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_res.count !== oldest.count) begin
                        $error("count: expected %0d, actual %0d", oldest.count, i_res.count);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                expected_results.push_back(apply_request(i_req));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> verif/tb_max_heap_priority_queue.sv
module tb_max_heap_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 1500;
    localparam int STALL_LIMIT  = 500;
    localparam int SETTLE       = 24;
    localparam int VALUE_W      = hpq_pkg::VALUE_W;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    // Mix of request kinds used for one burst of random items.
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    hpq_pkg::t_hpq_req i_req;
    logic              busy;
    logic              o_done;
    hpq_pkg::t_hpq_res o_res;

    int       fail_count;
    int       pending_count;
    int       stall_cycles;
    logic     idle_enable;

    max_heap_priority_queue #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_req  (i_req),
        .busy   (busy),
        .o_done (o_done),
        .o_res  (o_res)
    );

    hpq_result_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_req       (i_req),
        .i_done      (o_done),
        .i_res       (o_res),
        .o_fail_count(fail_count),
        .o_pending   (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: ends the run when neither an item nor a result moves for too long.
    always @(posedge i_clk) begin
        if ((i_rst_n && start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("max_heap_priority_queue regression: fail");
            $finish;
        end
    end

    // Random value, weighted toward the extremes and a narrow band that makes ties.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return $signed(VALUE_W'($urandom_range(6))) - 3;
            default: return $signed(VALUE_W'($urandom));
        endcase
    endfunction

    // Offers one item after optional idle cycles and returns once it is accepted.
    task automatic issue_request(input logic kind, input logic signed [VALUE_W-1:0] val);
        while (idle_enable && ($urandom_range(99) < 36)) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= '{req_type: kind, value: val};
        do @(posedge i_clk); while (busy);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    initial begin
        t_mix mix;
        int   burst;
        int   insert_pct;
        int   sent;
        logic kind;
        stall_cycles = 0;
        idle_enable  = 1'b1;
        start        = 1'b0;
        i_req        = '0;
        i_rst_n      = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: delete from empty, fill with extremes, ties and a rising run, overflow, then deletes.
        issue_request(hpq_pkg::REQ_DELETE, VAL_MAX);
        issue_request(hpq_pkg::REQ_INSERT, '0);
        issue_request(hpq_pkg::REQ_INSERT, VAL_MAX);
        issue_request(hpq_pkg::REQ_INSERT, VAL_MIN);
        issue_request(hpq_pkg::REQ_INSERT, -1);
        issue_request(hpq_pkg::REQ_INSERT, 1);
        for (int k = 0; k < 3; k++) begin
            issue_request(hpq_pkg::REQ_INSERT, 5);
        end
        for (int k = 0; k < 8; k++) begin
            issue_request(hpq_pkg::REQ_INSERT, VAL_MIN + k);
        end
        issue_request(hpq_pkg::REQ_INSERT, VAL_MAX);
        for (int k = 0; k < 7; k++) begin
            issue_request(hpq_pkg::REQ_DELETE, VAL_MIN);
        end
        wait_drained();

        // Random bursts, each a fill, drain or even mix picked at random, to drive the queue past both limits.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mix   = t_mix'($urandom_range(2));
            burst = $urandom_range(40, 4);
            case (mix)
                MIX_FILL:  insert_pct = 85;
                MIX_DRAIN: insert_pct = 15;
                default:   insert_pct = 50;
            endcase
            for (int k = 0; k < burst; k++) begin
                idle_enable = !(sent >= 600 && sent < 900);
                kind        = ($urandom_range(99) < insert_pct) ? hpq_pkg::REQ_INSERT
                                                                : hpq_pkg::REQ_DELETE;
                issue_request(kind, pick_value());
                sent = sent + 1;
                if (sent == 1100) begin
                    wait_drained();
                end
            end
        end

        // Let the last results arrive and give stray strobes a chance to show.
        wait_drained();
        repeat (SETTLE) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("max_heap_priority_queue regression: pass");
        end else begin
            $display("max_heap_priority_queue regression: fail");
        end
        $finish;
    end

endmodule
